/* sv/dbt_pkg.sv */
// Shared types, constants and helpers of the debounced tachometer.
// Used by dbt_debounce, dbt_rate and debounced_tachometer_unit; no dependencies.
`default_nettype none

package dbt_pkg;

   localparam int CSR_WIDTH             = 32;
   localparam int CSR_INDEX_WIDTH       = 1;
   localparam int DEFAULT_FINS_PER_REV  = 8;
   localparam int DEFAULT_COUNT_WIDTH   = 16;
   localparam int DEFAULT_TIMER_WIDTH   = 32;
   localparam int RPM_WIDTH             = 19;
   localparam int SEC_PER_MIN           = 60;

   localparam logic [RPM_WIDTH-1:0] RPM_MAX = '1;

   localparam logic [CSR_WIDTH-1:0] DEBOUNCE_RESET = 32'd20000;
   localparam logic [CSR_WIDTH-1:0] REFRESH_RESET  = 32'd1000000;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REFRESH  = 1'b1;

   // Phase codes as seen on the result channel.
   localparam logic [1:0] CODE_UP      = 2'd0;
   localparam logic [1:0] CODE_FALLING = 2'd1;
   localparam logic [1:0] CODE_DOWN    = 2'd2;
   localparam logic [1:0] CODE_RISING  = 2'd3;

   typedef enum logic [3:0] {
      PH_UP      = 4'b0001,
      PH_FALLING = 4'b0010,
      PH_DOWN    = 4'b0100,
      PH_RISING  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       stable_level;
      logic [1:0] phase_code;
      logic       blade;
   } debounce_status_type;

   typedef struct packed {
      logic [RPM_WIDTH-1:0] rpm;
      logic                 updated;
   } rate_status_type;

   typedef struct packed {
      logic                 stable_level;
      logic [1:0]           debounce_phase;
      logic [RPM_WIDTH-1:0] rpm;
      logic                 rpm_updated;
   } result_type;

   function automatic logic [1:0] phase_code(input phase_type p);
      logic [1:0] code;
      unique case (p)
         PH_UP:      code = CODE_UP;
         PH_FALLING: code = CODE_FALLING;
         PH_DOWN:    code = CODE_DOWN;
         PH_RISING:  code = CODE_RISING;
         default:    code = CODE_DOWN;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

/* sv/dbt_debounce.sv */
// Four-phase level debouncer with a saturating hold timer.
// Depends on dbt_pkg for the phase type and the status struct.
`default_nettype none

module dbt_debounce import dbt_pkg::*; #(
   parameter int TIMER_WIDTH = DEFAULT_TIMER_WIDTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic                 pin_level,
   input  wire logic [CSR_WIDTH-1:0] debounce_ticks,
   output debounce_status_type       status
);

   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

   phase_type              phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0] hold_ff, hold_in;
   logic [TIMER_WIDTH-1:0] hold_inc;
   logic                   exceeded;
   logic                   blade;

   assign hold_inc = (hold_ff == TIMER_MAX) ? hold_ff : hold_ff + 1'b1;
   assign exceeded = CSR_WIDTH'(hold_inc) > debounce_ticks;

   always_comb begin
      phase_in = phase_ff;
      hold_in  = hold_ff;
      blade    = 1'b0;
      unique case (phase_ff)
         PH_UP: begin
            if (!pin_level) begin
               phase_in = PH_FALLING;
               hold_in  = '0;
            end
         end
         PH_FALLING: begin
            if (pin_level) begin
               phase_in = PH_UP;
            end else begin
               hold_in = hold_inc;
               if (exceeded) begin
                  phase_in = PH_DOWN;
               end
            end
         end
         PH_DOWN: begin
            if (pin_level) begin
               phase_in = PH_RISING;
               hold_in  = '0;
            end
         end
         PH_RISING: begin
            if (!pin_level) begin
               phase_in = PH_DOWN;
            end else begin
               hold_in = hold_inc;
               if (exceeded) begin
                  phase_in = PH_UP;
                  blade    = 1'b1;
               end
            end
         end
         default: begin
            phase_in = PH_DOWN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DOWN;
         hold_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hold_ff  <= hold_in;
      end
   end

   // The status reflects the phase after this item's update.
   assign status.stable_level = (phase_in == PH_UP) || (phase_in == PH_FALLING);
   assign status.phase_code   = phase_code(phase_in);
   assign status.blade        = blade;

endmodule

`default_nettype wire

/* sv/dbt_rate.sv */
// Blade counter, measurement window and rpm computation.
// Depends on dbt_pkg; the rpm quotient is built up blade by blade.
`default_nettype none

module dbt_rate import dbt_pkg::*; #(
   parameter int FINS_PER_REV = DEFAULT_FINS_PER_REV,
   parameter int COUNT_WIDTH  = DEFAULT_COUNT_WIDTH,
   parameter int TIMER_WIDTH  = DEFAULT_TIMER_WIDTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic                 blade,
   input  wire logic [CSR_WIDTH-1:0] refresh_ticks,
   output rate_status_type           status
);

   // Each blade adds 60/FINS_PER_REV to the quotient and the remainder of that
   // division to a running remainder, so the quotient always equals
   // floor(count * 60 / FINS_PER_REV) without a divider.
   localparam int QUOT_STEP = SEC_PER_MIN / FINS_PER_REV;
   localparam int REM_STEP  = SEC_PER_MIN % FINS_PER_REV;
   localparam int REM_WIDTH = $clog2(2 * FINS_PER_REV);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [RPM_WIDTH-1:0]   quot_ff, quot_in;
   logic [REM_WIDTH-1:0]   rem_ff, rem_in;
   logic [TIMER_WIDTH-1:0] window_ff, window_in;
   logic [RPM_WIDTH-1:0]   rpm_ff, rpm_in;
   logic                   counted;
   logic [REM_WIDTH-1:0]   rem_sum;
   logic                   carry;
   logic [RPM_WIDTH:0]     quot_sum;
   logic [RPM_WIDTH-1:0]   quot_next;
   logic [TIMER_WIDTH-1:0] window_inc;
   logic                   update;

   assign counted  = blade && (count_ff != COUNT_MAX);
   assign rem_sum  = rem_ff + REM_WIDTH'(REM_STEP);
   assign carry    = rem_sum >= REM_WIDTH'(FINS_PER_REV);
   assign quot_sum = {1'b0, quot_ff} + (RPM_WIDTH + 1)'(QUOT_STEP)
                     + (RPM_WIDTH + 1)'(carry);
   // The quotient only grows, so clamping it here is the same as clamping the
   // final result.
   assign quot_next = (quot_sum > {1'b0, RPM_MAX}) ? RPM_MAX : quot_sum[RPM_WIDTH-1:0];

   assign window_inc = (window_ff == TIMER_MAX) ? window_ff : window_ff + 1'b1;
   assign update     = CSR_WIDTH'(window_inc) > refresh_ticks;

   always_comb begin
      count_in  = count_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      window_in = window_inc;
      rpm_in    = rpm_ff;
      if (counted) begin
         count_in = count_ff + 1'b1;
         quot_in  = quot_next;
         rem_in   = carry ? rem_sum - REM_WIDTH'(FINS_PER_REV) : rem_sum;
      end
      // A blade confirmed on this item is part of the rpm taken now.
      if (update) begin
         rpm_in    = quot_in;
         count_in  = '0;
         quot_in   = '0;
         rem_in    = '0;
         window_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         quot_ff   <= '0;
         rem_ff    <= '0;
         window_ff <= '0;
         rpm_ff    <= '0;
      end else if (accept) begin
         count_ff  <= count_in;
         quot_ff   <= quot_in;
         rem_ff    <= rem_in;
         window_ff <= window_in;
         rpm_ff    <= rpm_in;
      end
   end

   assign status.rpm     = rpm_in;
   assign status.updated = update;

   window_clears_on_update: assert property (
      @(posedge clock) disable iff (reset)
      accept && update |=> window_ff == '0 && count_ff == '0 && quot_ff == '0
   ) else $error("window state not cleared after an rpm update");

   blade_counts_once: assert property (
      @(posedge clock) disable iff (reset)
      accept && !update && blade && count_ff != COUNT_MAX
      |=> count_ff == COUNT_WIDTH'($past(count_ff) + 1'b1)
   ) else $error("confirmed blade not counted exactly once");

   remainder_below_divisor: assert property (
      @(posedge clock) disable iff (reset)
      rem_ff < REM_WIDTH'(FINS_PER_REV)
   ) else $error("running remainder reached the fin count");

endmodule

`default_nettype wire

/* sv/debounced_tachometer_unit.sv */
// Debounced tachometer top level: config registers, debouncer, rate unit, output skid.
// Results are registered in the result register, or in the skid while it is stalled.
// Throughput: one item per cycle while the skid is empty; the per-item update is one
// pass through the phase logic and the counter adders between the state registers.
// A two-entry output stage (result register plus skid) lets items keep coming while
// one result waits. Reset is synchronous; it clears all but the result and skid data.
`default_nettype none

module debounced_tachometer_unit import dbt_pkg::*; #(
   parameter int FINS_PER_REV = DEFAULT_FINS_PER_REV,
   parameter int COUNT_WIDTH  = DEFAULT_COUNT_WIDTH,
   parameter int TIMER_WIDTH  = DEFAULT_TIMER_WIDTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_pin_level,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_stable_level,
   output logic [1:0]                      rsp_debounce_phase,
   output logic [RPM_WIDTH-1:0]            rsp_rpm,
   output logic                            rsp_rpm_updated,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_WIDTH-1:0]       csr_write_data
);

   logic [CSR_WIDTH-1:0] debounce_ticks_ff;
   logic [CSR_WIDTH-1:0] refresh_ticks_ff;
   debounce_status_type  deb_status;
   rate_status_type      rate_status;
   result_type           result;
   result_type           rsp_ff, skid_ff;
   logic                 rsp_valid_ff, skid_valid_ff;
   logic                 accept;
   logic                 take;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= DEBOUNCE_RESET;
         refresh_ticks_ff  <= REFRESH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEBOUNCE: debounce_ticks_ff <= csr_write_data;
            CSR_REFRESH:  refresh_ticks_ff  <= csr_write_data;
         endcase
      end
   end

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign take      = rsp_valid_ff && !rsp_stall;

   dbt_debounce #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_debounce (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .pin_level     (req_pin_level),
      .debounce_ticks(debounce_ticks_ff),
      .status        (deb_status)
   );

   dbt_rate #(
      .FINS_PER_REV(FINS_PER_REV),
      .COUNT_WIDTH (COUNT_WIDTH),
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_rate (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .blade        (deb_status.blade),
      .refresh_ticks(refresh_ticks_ff),
      .status       (rate_status)
   );

   assign result.stable_level   = deb_status.stable_level;
   assign result.debounce_phase = deb_status.phase_code;
   assign result.rpm            = rate_status.rpm;
   assign result.rpm_updated    = rate_status.updated;

   // While the skid holds an item no new item is accepted, so the skid only
   // ever drains into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            rsp_ff <= skid_ff;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || take) begin
            rsp_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_stable_level   = rsp_ff.stable_level;
   assign rsp_debounce_phase = rsp_ff.debounce_phase;
   assign rsp_rpm            = rsp_ff.rpm;
   assign rsp_rpm_updated    = rsp_ff.rpm_updated;

   skid_behind_result: assert property (
      @(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff
   ) else $error("skid holds an item while the result register is empty");

   stalled_item_goes_to_skid: assert property (
      @(posedge clock) disable iff (reset)
      accept && rsp_valid_ff && rsp_stall |=> skid_valid_ff && rsp_valid_ff
   ) else $error("item accepted behind a stalled result was lost");

   drained_skid_refills_result: assert property (
      @(posedge clock) disable iff (reset)
      skid_valid_ff && take |=> rsp_valid_ff && !skid_valid_ff
   ) else $error("skid item not moved to the result register");

endmodule

`default_nettype wire
